// File: src/trbm_pkg.sv
// Shared types, codes and constants of the three-layer perceptron core.
// Used by every module of the core; depends on nothing.
package trbm_pkg;

   localparam int MAX_INPUTS        = 64;
   localparam int MAX_FIRST_HIDDEN  = 64;
   localparam int MAX_SECOND_HIDDEN = 64;
   localparam int MAX_OUTPUTS       = 64;
   localparam int RESULT_CAP        = 64;
   localparam int DRAIN_CYCLES      = 5;
   localparam int COUNT_RESET       = 64;

   localparam logic [1:0] FUNC_WEIGHT  = 2'd0;
   localparam logic [1:0] FUNC_RECIP   = 2'd1;
   localparam logic [1:0] FUNC_OFFSET  = 2'd2;
   localparam logic [1:0] FUNC_FEATURE = 2'd3;

   localparam logic [1:0] LAYER_FIRST  = 2'd0;
   localparam logic [1:0] LAYER_SECOND = 2'd1;
   localparam logic [1:0] LAYER_THIRD  = 2'd2;

   localparam logic [1:0] CSR_INPUT_COUNT   = 2'd0;
   localparam logic [1:0] CSR_FIRST_HIDDEN  = 2'd1;
   localparam logic [1:0] CSR_SECOND_HIDDEN = 2'd2;
   localparam logic [1:0] CSR_OUTPUT_COUNT  = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         layer;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [31:0] value;
      logic               last;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  out_index;
      logic [30:0] out_value;
      logic        out_last;
   } rsp_word_type;

   typedef struct packed {
      logic       step_valid;
      logic       step_first;
      logic       step_last;
      logic [1:0] layer;
      logic       final_neuron;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } status_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// File: src/trbm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on trbm_pkg for the address width helper.
module trbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [trbm_pkg::addr_width(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [trbm_pkg::addr_width(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/trbm_ctrl.sv
// Sequencer of the perceptron core: configuration registers, layer, neuron
// and column counters, and the step commands for the datapath. Uses trbm_pkg.
module trbm_ctrl #(
   parameter int MAX_INPUTS        = trbm_pkg::MAX_INPUTS,
   parameter int MAX_FIRST_HIDDEN  = trbm_pkg::MAX_FIRST_HIDDEN,
   parameter int MAX_SECOND_HIDDEN = trbm_pkg::MAX_SECOND_HIDDEN,
   parameter int MAX_OUTPUTS       = trbm_pkg::MAX_OUTPUTS,
   localparam int MAXN_A = (MAX_INPUTS > MAX_FIRST_HIDDEN) ? MAX_INPUTS : MAX_FIRST_HIDDEN,
   localparam int MAXN_B = (MAX_SECOND_HIDDEN > MAX_OUTPUTS) ? MAX_SECOND_HIDDEN : MAX_OUTPUTS,
   localparam int MAXN   = (MAXN_A > MAXN_B) ? MAXN_A : MAXN_B,
   localparam int CW     = $clog2(MAXN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [6:0]             csr_wdata,
   input  logic                   start,
   input  trbm_pkg::status_type   status,
   output logic                   busy,
   output trbm_pkg::cmd_type      cmd,
   output logic [CW-1:0]          neuron_idx,
   output logic [CW-1:0]          col_idx
);

   localparam int OUT_CAP = (MAX_OUTPUTS < trbm_pkg::RESULT_CAP) ?
                            MAX_OUTPUTS : trbm_pkg::RESULT_CAP;
   localparam int DW = $clog2(trbm_pkg::DRAIN_CYCLES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_WAITO = 2'd3;

   function automatic logic [CW-1:0] clamp(input logic [6:0] c, input int maxv);
      if (c == 7'd0) begin
         return CW'(1);
      end
      if (int'(c) > maxv) begin
         return CW'(maxv);
      end
      return CW'(c);
   endfunction

   logic [6:0]    ni_cfg_ff, nh1_cfg_ff, nh2_cfg_ff, no_cfg_ff;
   logic [6:0]    ni_cfg_in, nh1_cfg_in, nh2_cfg_in, no_cfg_in;
   logic [1:0]    state_ff, state_in;
   logic [1:0]    layer_ff, layer_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [DW-1:0] drain_ff, drain_in;
   logic [CW-1:0] ni, nh1, nh2, no, n_cols, n_neur;
   logic          col_end, neuron_end;

   assign ni  = clamp(ni_cfg_ff, MAX_INPUTS);
   assign nh1 = clamp(nh1_cfg_ff, MAX_FIRST_HIDDEN);
   assign nh2 = clamp(nh2_cfg_ff, MAX_SECOND_HIDDEN);
   assign no  = clamp(no_cfg_ff, OUT_CAP);

   always_comb begin
      case (layer_ff)
         trbm_pkg::LAYER_FIRST: begin
            n_cols = ni;
            n_neur = nh1;
         end
         trbm_pkg::LAYER_SECOND: begin
            n_cols = nh1;
            n_neur = nh2;
         end
         default: begin
            n_cols = nh2;
            n_neur = no;
         end
      endcase
   end

   assign col_end    = (j_ff == n_cols - CW'(1));
   assign neuron_end = (i_ff == n_neur - CW'(1));

   always_comb begin
      ni_cfg_in  = ni_cfg_ff;
      nh1_cfg_in = nh1_cfg_ff;
      nh2_cfg_in = nh2_cfg_ff;
      no_cfg_in  = no_cfg_ff;
      if (csr_we) begin
         case (csr_index)
            trbm_pkg::CSR_INPUT_COUNT:   ni_cfg_in  = csr_wdata;
            trbm_pkg::CSR_FIRST_HIDDEN:  nh1_cfg_in = csr_wdata;
            trbm_pkg::CSR_SECOND_HIDDEN: nh2_cfg_in = csr_wdata;
            trbm_pkg::CSR_OUTPUT_COUNT:  no_cfg_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      drain_in = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MAC;
               layer_in = trbm_pkg::LAYER_FIRST;
               i_in     = '0;
               j_in     = '0;
            end
         end
         ST_MAC: begin
            if (col_end) begin
               j_in     = '0;
               drain_in = DW'(trbm_pkg::DRAIN_CYCLES - 1);
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_ff != '0) begin
               drain_in = drain_ff - DW'(1);
            end else if (neuron_end) begin
               i_in = '0;
               if (layer_ff == trbm_pkg::LAYER_THIRD) begin
                  state_in = ST_IDLE;
               end else begin
                  layer_in = layer_ff + 2'd1;
                  state_in = (layer_ff == trbm_pkg::LAYER_SECOND) ? ST_WAITO : ST_MAC;
               end
            end else begin
               i_in     = i_ff + CW'(1);
               state_in = (layer_ff == trbm_pkg::LAYER_THIRD) ? ST_WAITO : ST_MAC;
            end
         end
         ST_WAITO: begin
            if (!status.rsp_busy) begin
               state_in = ST_MAC;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         layer_ff   <= trbm_pkg::LAYER_FIRST;
         i_ff       <= '0;
         j_ff       <= '0;
         drain_ff   <= '0;
         ni_cfg_ff  <= 7'(trbm_pkg::COUNT_RESET);
         nh1_cfg_ff <= 7'(trbm_pkg::COUNT_RESET);
         nh2_cfg_ff <= 7'(trbm_pkg::COUNT_RESET);
         no_cfg_ff  <= 7'(trbm_pkg::COUNT_RESET);
      end else begin
         state_ff   <= state_in;
         layer_ff   <= layer_in;
         i_ff       <= i_in;
         j_ff       <= j_in;
         drain_ff   <= drain_in;
         ni_cfg_ff  <= ni_cfg_in;
         nh1_cfg_ff <= nh1_cfg_in;
         nh2_cfg_ff <= nh2_cfg_in;
         no_cfg_ff  <= no_cfg_in;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign cmd.step_valid   = (state_ff == ST_MAC);
   assign cmd.step_first   = (j_ff == '0);
   assign cmd.step_last    = col_end;
   assign cmd.layer        = layer_ff;
   assign cmd.final_neuron = neuron_end;
   assign neuron_idx       = i_ff;
   assign col_idx          = j_ff;

   // A drain only ever follows the last column of a neuron.
   a_drain_after_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && $past(state_ff) == ST_MAC) |-> $past(col_end))
      else $error("drain entered before the last column");

endmodule

// File: src/trbm_datapath.sv
// Datapath of the perceptron core: parameter and activation memories, the
// multiply-accumulate pipeline, ReLU, batch norm and the result register.
// Uses trbm_pkg and trbm_ram.
module trbm_datapath #(
   parameter int MAX_INPUTS        = trbm_pkg::MAX_INPUTS,
   parameter int MAX_FIRST_HIDDEN  = trbm_pkg::MAX_FIRST_HIDDEN,
   parameter int MAX_SECOND_HIDDEN = trbm_pkg::MAX_SECOND_HIDDEN,
   parameter int MAX_OUTPUTS       = trbm_pkg::MAX_OUTPUTS,
   localparam int MAXN_A = (MAX_INPUTS > MAX_FIRST_HIDDEN) ? MAX_INPUTS : MAX_FIRST_HIDDEN,
   localparam int MAXN_B = (MAX_SECOND_HIDDEN > MAX_OUTPUTS) ? MAX_SECOND_HIDDEN : MAX_OUTPUTS,
   localparam int MAXN   = (MAXN_A > MAXN_B) ? MAXN_A : MAXN_B,
   localparam int CW     = $clog2(MAXN + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_load,
   input  trbm_pkg::req_word_type req_word,
   input  trbm_pkg::cmd_type      cmd,
   input  logic [CW-1:0]          neuron_idx,
   input  logic [CW-1:0]          col_idx,
   output trbm_pkg::status_type   status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output trbm_pkg::rsp_word_type rsp_word
);

   localparam int W1D = MAX_FIRST_HIDDEN * MAX_INPUTS;
   localparam int W2D = MAX_SECOND_HIDDEN * MAX_FIRST_HIDDEN;
   localparam int W3D = MAX_OUTPUTS * MAX_SECOND_HIDDEN;
   localparam int ND  = MAX_FIRST_HIDDEN + MAX_SECOND_HIDDEN;
   localparam int W1A = trbm_pkg::addr_width(W1D);
   localparam int W2A = trbm_pkg::addr_width(W2D);
   localparam int W3A = trbm_pkg::addr_width(W3D);
   localparam int NA  = trbm_pkg::addr_width(ND);
   localparam int FA  = trbm_pkg::addr_width(MAX_INPUTS);
   localparam int H1A = trbm_pkg::addr_width(MAX_FIRST_HIDDEN);
   localparam int H2A = trbm_pkg::addr_width(MAX_SECOND_HIDDEN);

   // Load decoding.
   logic           is_w, is_norm, we_w1, we_w2, we_w3, we_nr, we_no, we_f, norm_ok;
   logic [W1A-1:0] w1_waddr, w1_raddr;
   logic [W2A-1:0] w2_waddr, w2_raddr;
   logic [W3A-1:0] w3_waddr, w3_raddr;
   logic [NA-1:0]  n_waddr, n_raddr;
   logic [31:0]    w1_rd, w2_rd, w3_rd, f_rd, h1_rd, h2_rd, recip_rd, off_rd;
   logic [31:0]    w_rd, a_rd, hval;
   logic           we_h1, we_h2;

   assign is_w    = req_load && (req_word.func == trbm_pkg::FUNC_WEIGHT);
   assign is_norm = req_load && (req_word.func == trbm_pkg::FUNC_RECIP ||
                                 req_word.func == trbm_pkg::FUNC_OFFSET);
   assign we_w1 = is_w && req_word.layer == trbm_pkg::LAYER_FIRST &&
                  int'(req_word.row) < MAX_FIRST_HIDDEN && int'(req_word.col) < MAX_INPUTS;
   assign we_w2 = is_w && req_word.layer == trbm_pkg::LAYER_SECOND &&
                  int'(req_word.row) < MAX_SECOND_HIDDEN &&
                  int'(req_word.col) < MAX_FIRST_HIDDEN;
   assign we_w3 = is_w && req_word.layer == trbm_pkg::LAYER_THIRD &&
                  int'(req_word.row) < MAX_OUTPUTS && int'(req_word.col) < MAX_SECOND_HIDDEN;
   assign norm_ok = (req_word.layer == trbm_pkg::LAYER_FIRST &&
                     int'(req_word.row) < MAX_FIRST_HIDDEN) ||
                    (req_word.layer == trbm_pkg::LAYER_SECOND &&
                     int'(req_word.row) < MAX_SECOND_HIDDEN);
   assign we_nr = is_norm && norm_ok && req_word.func == trbm_pkg::FUNC_RECIP;
   assign we_no = is_norm && norm_ok && req_word.func == trbm_pkg::FUNC_OFFSET;
   assign we_f  = req_load && req_word.func == trbm_pkg::FUNC_FEATURE &&
                  int'(req_word.col) < MAX_INPUTS;

   assign w1_waddr = W1A'(int'(req_word.row) * MAX_INPUTS + int'(req_word.col));
   assign w2_waddr = W2A'(int'(req_word.row) * MAX_FIRST_HIDDEN + int'(req_word.col));
   assign w3_waddr = W3A'(int'(req_word.row) * MAX_SECOND_HIDDEN + int'(req_word.col));
   assign n_waddr  = (req_word.layer == trbm_pkg::LAYER_FIRST) ? NA'(req_word.row) :
                     NA'(MAX_FIRST_HIDDEN + int'(req_word.row));

   assign w1_raddr = W1A'(int'(neuron_idx) * MAX_INPUTS + int'(col_idx));
   assign w2_raddr = W2A'(int'(neuron_idx) * MAX_FIRST_HIDDEN + int'(col_idx));
   assign w3_raddr = W3A'(int'(neuron_idx) * MAX_SECOND_HIDDEN + int'(col_idx));
   assign n_raddr  = (cmd.layer == trbm_pkg::LAYER_FIRST) ? NA'(neuron_idx) :
                     NA'(MAX_FIRST_HIDDEN + int'(neuron_idx));

   trbm_ram #(.WIDTH(32), .DEPTH(W1D)) u_w1 (.clock(clock), .we(we_w1), .waddr(w1_waddr),
      .wdata(req_word.value), .raddr(w1_raddr), .rdata(w1_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(W2D)) u_w2 (.clock(clock), .we(we_w2), .waddr(w2_waddr),
      .wdata(req_word.value), .raddr(w2_raddr), .rdata(w2_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(W3D)) u_w3 (.clock(clock), .we(we_w3), .waddr(w3_waddr),
      .wdata(req_word.value), .raddr(w3_raddr), .rdata(w3_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(ND)) u_recip (.clock(clock), .we(we_nr), .waddr(n_waddr),
      .wdata(req_word.value), .raddr(n_raddr), .rdata(recip_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(ND)) u_off (.clock(clock), .we(we_no), .waddr(n_waddr),
      .wdata(req_word.value), .raddr(n_raddr), .rdata(off_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS)) u_feat (.clock(clock), .we(we_f),
      .waddr(FA'(req_word.col)), .wdata(req_word.value), .raddr(FA'(col_idx)),
      .rdata(f_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(MAX_FIRST_HIDDEN)) u_h1 (.clock(clock), .we(we_h1),
      .waddr(H1A'(neuron_idx)), .wdata(hval), .raddr(H1A'(col_idx)), .rdata(h1_rd));
   trbm_ram #(.WIDTH(32), .DEPTH(MAX_SECOND_HIDDEN)) u_h2 (.clock(clock), .we(we_h2),
      .waddr(H2A'(neuron_idx)), .wdata(hval), .raddr(H2A'(col_idx)), .rdata(h2_rd));

   always_comb begin
      case (cmd.layer)
         trbm_pkg::LAYER_FIRST: begin
            w_rd = w1_rd;
            a_rd = f_rd;
         end
         trbm_pkg::LAYER_SECOND: begin
            w_rd = w2_rd;
            a_rd = h1_rd;
         end
         default: begin
            w_rd = w3_rd;
            a_rd = h2_rd;
         end
      endcase
   end

   // Pipeline: read, multiply, accumulate, ReLU, norm multiply, norm subtract.
   logic               s1_v_ff, s1_first_ff, s1_last_ff;
   logic               s2_v_ff, s2_first_ff, s2_last_ff;
   logic               fin1_ff, fin2_ff, fin3_ff;
   logic signed [63:0] prod_ff, prod_in, acc_ff, acc_in, bp_ff, bp_in, t_val, off_ext;
   logic [30:0]        r_ff, r_in;
   logic               cap;
   logic               rsp_valid_ff, rsp_valid_in;
   trbm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   assign prod_in = $signed(w_rd) * $signed(a_rd);
   assign acc_in  = s2_first_ff ? (prod_ff >>> 16) : (acc_ff + (prod_ff >>> 16));

   always_comb begin
      if (acc_ff[63]) begin
         r_in = '0;
      end else if (|acc_ff[62:31]) begin
         r_in = '1;
      end else begin
         r_in = acc_ff[30:0];
      end
   end

   assign bp_in   = $signed({1'b0, r_ff}) * $signed(recip_rd);
   assign off_ext = {{32{off_rd[31]}}, off_rd};
   assign t_val   = (bp_ff >>> 16) - off_ext;

   always_comb begin
      if (t_val[63:31] == {33{t_val[63]}}) begin
         hval = t_val[31:0];
      end else if (t_val[63]) begin
         hval = 32'h8000_0000;
      end else begin
         hval = 32'h7FFF_FFFF;
      end
   end

   assign we_h1 = fin3_ff && cmd.layer == trbm_pkg::LAYER_FIRST;
   assign we_h2 = fin3_ff && cmd.layer == trbm_pkg::LAYER_SECOND;
   assign cap   = fin2_ff && cmd.layer == trbm_pkg::LAYER_THIRD;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      if (cap) begin
         rsp_valid_in          = 1'b1;
         rsp_word_in.out_index = 6'(neuron_idx);
         rsp_word_in.out_value = r_ff;
         rsp_word_in.out_last  = cmd.final_neuron;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         fin1_ff      <= 1'b0;
         fin2_ff      <= 1'b0;
         fin3_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_v_ff      <= cmd.step_valid;
         s2_v_ff      <= s1_v_ff;
         fin1_ff      <= s2_v_ff && s2_last_ff;
         fin2_ff      <= fin1_ff;
         fin3_ff      <= fin2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.step_first;
      s1_last_ff  <= cmd.step_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      rsp_word_ff <= rsp_word_in;
      if (s1_v_ff) begin
         prod_ff <= prod_in;
      end
      if (s2_v_ff) begin
         acc_ff <= acc_in;
      end
      if (fin1_ff) begin
         r_ff <= r_in;
      end
      if (fin2_ff) begin
         bp_ff <= bp_in;
      end
   end

   assign status.rsp_busy = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = rsp_word_ff;

   a_cap_into_empty: assert property (@(posedge clock) disable iff (reset)
      cap |-> !rsp_valid_ff)
      else $error("result captured over an undelivered word");

   a_write_after_drain: assert property (@(posedge clock) disable iff (reset)
      fin3_ff |-> (!s1_v_ff && !s2_v_ff))
      else $error("hidden value written while products still in flight");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> $past(cap))
      else $error("result word appeared without a capture");

endmodule

// File: src/three_layer_relu_batchnorm_mlp_core.sv
// Top level of the three-layer perceptron inference core.
// Uses trbm_pkg, trbm_ctrl, trbm_datapath and, through it, trbm_ram.
//
// Usage. Request words arrive on req_valid/req_stall/req_word. A weight,
// norm reciprocal or norm offset word writes one entry of the parameter
// memories; a feature word writes one input feature, and with last set it
// also starts an inference pass: layer one, ReLU and batch norm, layer two
// likewise, then layer three with ReLU. Load words are taken while idle.
// During a pass req_stall stays high. A pass runs one multiply-accumulate
// per cycle on a single MAC unit, drains the ReLU and batch-norm pipeline
// after every neuron, and before each output neuron waits until the output
// register is seen free.
// Result words leave through a single output register on rsp_valid,
// rsp_stall and rsp_word; while the receiver stalls, the core holds the
// word and waits before starting the next output neuron.
// Reset is synchronous: it idles the sequencer, empties the output register
// and sets all four counts to 64. Memories are not cleared.
// Counts are written through csr_we, csr_index and csr_wdata; the user must
// write them only while idle, which the block itself does not enforce.
module three_layer_relu_batchnorm_mlp_core #(
   parameter int MAX_INPUTS        = trbm_pkg::MAX_INPUTS,
   parameter int MAX_FIRST_HIDDEN  = trbm_pkg::MAX_FIRST_HIDDEN,
   parameter int MAX_SECOND_HIDDEN = trbm_pkg::MAX_SECOND_HIDDEN,
   parameter int MAX_OUTPUTS       = trbm_pkg::MAX_OUTPUTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  trbm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output trbm_pkg::rsp_word_type rsp_word,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [6:0]             csr_wdata
);

   localparam int MAXN_A = (MAX_INPUTS > MAX_FIRST_HIDDEN) ? MAX_INPUTS : MAX_FIRST_HIDDEN;
   localparam int MAXN_B = (MAX_SECOND_HIDDEN > MAX_OUTPUTS) ? MAX_SECOND_HIDDEN : MAX_OUTPUTS;
   localparam int MAXN   = (MAXN_A > MAXN_B) ? MAXN_A : MAXN_B;
   localparam int CW     = $clog2(MAXN + 1);

   logic                 busy, req_take, start;
   trbm_pkg::cmd_type    cmd;
   trbm_pkg::status_type status;
   logic [CW-1:0]        neuron_idx, col_idx;

   // The sequencer is busy for the whole of a pass, so loads only land
   // while no memory is being read by the datapath.
   assign req_stall = busy;
   assign req_take  = req_valid && !busy;
   assign start     = req_take && req_word.func == trbm_pkg::FUNC_FEATURE && req_word.last;

   trbm_ctrl #(
      .MAX_INPUTS(MAX_INPUTS), .MAX_FIRST_HIDDEN(MAX_FIRST_HIDDEN),
      .MAX_SECOND_HIDDEN(MAX_SECOND_HIDDEN), .MAX_OUTPUTS(MAX_OUTPUTS)
   ) u_ctrl (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .start(start), .status(status), .busy(busy),
      .cmd(cmd), .neuron_idx(neuron_idx), .col_idx(col_idx)
   );

   trbm_datapath #(
      .MAX_INPUTS(MAX_INPUTS), .MAX_FIRST_HIDDEN(MAX_FIRST_HIDDEN),
      .MAX_SECOND_HIDDEN(MAX_SECOND_HIDDEN), .MAX_OUTPUTS(MAX_OUTPUTS)
   ) u_datapath (
      .clock(clock), .reset(reset), .req_load(req_take), .req_word(req_word),
      .cmd(cmd), .neuron_idx(neuron_idx), .col_idx(col_idx), .status(status),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

endmodule
